// ----- src/nfba_pkg.sv -----
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants of the next-fit bitmap slot allocator: request
// and response words, status codes and the scan unit result.
// ----------------------------------------------------------------------------
package nfba_pkg;

    localparam int SLOT_W    = 11;  // slot number and active size
    localparam int IDX_W     = 10;  // slot number on the ports
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int WSEL_W    = SLOT_W - BIT_W;
    localparam int CNT_W     = 7;   // bit bound within a word, 0 to 64
    localparam int VISIT_W   = WSEL_W + 1;
    localparam int SIZE_MAX  = 2047;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_BAD  = 2'd2;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [IDX_W-1:0]   release_index;
    } t_alloc_req;

    typedef struct packed {
        logic [IDX_W-1:0]   granted_index;
        t_status            status;
    } t_alloc_rsp;

    typedef struct packed {
        logic               found;
        logic [BIT_W-1:0]   bit_idx;
    } t_scan_res;

endpackage

// ----- src/nfba_mark_ram.sv -----
// ----------------------------------------------------------------------------
// nfba_mark_ram
// Single-port store of used-mark words, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module nfba_mark_ram #(
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic [nfba_pkg::WORD_BITS-1:0] i_wdata,
    output logic [nfba_pkg::WORD_BITS-1:0] o_rdata
);
    import nfba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/nfba_word_scan.sv -----
// ----------------------------------------------------------------------------
// nfba_word_scan
// Find the lowest free slot of one mark word inside the bit window [lo, hi).
// ----------------------------------------------------------------------------
module nfba_word_scan (
    input  logic [nfba_pkg::WORD_BITS-1:0] i_word,
    input  logic [nfba_pkg::CNT_W-1:0]     i_lo,
    input  logic [nfba_pkg::CNT_W-1:0]     i_hi,
    output nfba_pkg::t_scan_res            o_res
);
    import nfba_pkg::*;

    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            free_bits[b] = !i_word[b] && (CNT_W'(b) >= i_lo) && (CNT_W'(b) < i_hi);
        end
    end

    always_comb begin
        o_res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_res.found   = 1'b1;
                o_res.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

// ----- src/next_fit_bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// next_fit_bitmap_id_allocator
// Next-fit slot allocator over a bitmap of used marks.
//
// A command word (acquire or release) is taken when start is high and busy
// is low. Exactly one response word follows, shown for one cycle with
// o_done high; the receiver cannot stall it.
// Release: an out-of-range index is answered without a read of the mark
// store, else the mark word is read, then checked and written back.
// Acquire: the word scan unit checks one 64-slot mark word per cycle
// from the remembered position, wrapping at the active size, and revisits
// the first word once. A full acquire takes the longest, since it checks
// every word and the first word again.
// The single port of the mark store sets the pace of one word per cycle.
// The active size register is written through i_cfg_valid/o_cfg_ready,
// always ready; write it only while the block is idle.
// After reset the mark store is cleared one word per cycle with busy high;
// the search position returns to zero and the active size to 1024.
// ----------------------------------------------------------------------------
module next_fit_bitmap_id_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  nfba_pkg::t_alloc_req         i_req,
    output logic                         o_done,
    output nfba_pkg::t_alloc_rsp         o_rsp,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [nfba_pkg::SLOT_W-1:0]  i_cfg_data
);
    import nfba_pkg::*;

    localparam int WORDS    = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SIZE_CAP = (MAX_SLOTS > SIZE_MAX) ? SIZE_MAX : MAX_SLOTS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_REL   = 5'b01000,
        S_RCHK  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic [SLOT_W-1:0]     r_active, n_active;
    logic [SLOT_W-1:0]     r_search, n_search;
    logic [SLOT_W-1:0]     r_size, n_size;
    logic [SLOT_W-1:0]     r_s0, n_s0;
    logic [SLOT_W-1:0]     r_rel, n_rel;
    logic [WSEL_W-1:0]     r_last_w, n_last_w;
    logic [CNT_W-1:0]      r_last_n, n_last_n;
    logic [VISIT_W-1:0]    r_nwords, n_nwords;
    logic [VISIT_W-1:0]    r_iss_k, n_iss_k;
    logic [WSEL_W-1:0]     r_iss_w, n_iss_w;
    logic                  r_dv, n_dv;
    logic [VISIT_W-1:0]    r_dk, n_dk;
    logic [WSEL_W-1:0]     r_dw, n_dw;
    logic                  r_done, n_done;
    t_alloc_rsp            r_rsp, n_rsp;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [SLOT_W-1:0]     size_eff, size_m1, s0, slot;
    logic [CNT_W-1:0]      scan_lo, scan_hi;
    t_scan_res             scan_res;
    logic                  accept, hit;
    logic [WORD_BITS-1:0]  set_mask, rel_mask;

    nfba_mark_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    nfba_word_scan u_scan (
        .i_word (ram_rdata),
        .i_lo   (scan_lo),
        .i_hi   (scan_hi),
        .o_res  (scan_res)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    assign size_eff = (r_active > SLOT_W'(SIZE_CAP)) ? SLOT_W'(SIZE_CAP) : r_active;
    assign size_m1  = size_eff - SLOT_W'(1);
    assign s0       = (r_search >= size_eff) ? '0 : r_search;

    assign scan_lo = (r_dk == '0) ? CNT_W'(r_s0[BIT_W-1:0]) : '0;
    assign scan_hi = (r_dk == r_nwords)  ? CNT_W'(r_s0[BIT_W-1:0]) :
                     (r_dw == r_last_w) ? r_last_n : CNT_W'(WORD_BITS);

    assign hit      = r_dv && scan_res.found;
    assign slot     = {r_dw, scan_res.bit_idx};
    assign set_mask = WORD_BITS'(1) << scan_res.bit_idx;
    assign rel_mask = WORD_BITS'(1) << r_rel[BIT_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = AW'(r_iss_w);
        ram_wdata = ram_rdata | set_mask;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_SCAN: begin
                if (hit) begin
                    ram_we   = 1'b1;
                    ram_addr = AW'(r_dw);
                end
            end
            S_REL: begin
                ram_addr = AW'(r_rel[SLOT_W-1:BIT_W]);
            end
            S_RCHK: begin
                ram_we    = ram_rdata[r_rel[BIT_W-1:0]];
                ram_addr  = AW'(r_rel[SLOT_W-1:BIT_W]);
                ram_wdata = ram_rdata & ~rel_mask;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_active = r_active;
        n_search = r_search;
        n_size   = r_size;
        n_s0     = r_s0;
        n_rel    = r_rel;
        n_last_w = r_last_w;
        n_last_n = r_last_n;
        n_nwords = r_nwords;
        n_iss_k  = r_iss_k;
        n_iss_w  = r_iss_w;
        n_dv     = 1'b0;
        n_dk     = r_dk;
        n_dw     = r_dw;
        n_done   = 1'b0;
        n_rsp    = r_rsp;

        if (i_cfg_valid) begin
            n_active = i_cfg_data;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_size   = size_eff;
                    n_s0     = s0;
                    n_rel    = SLOT_W'(i_req.release_index);
                    n_last_w = size_m1[SLOT_W-1:BIT_W];
                    n_last_n = CNT_W'(size_m1[BIT_W-1:0]) + CNT_W'(1);
                    n_nwords = VISIT_W'(size_m1[SLOT_W-1:BIT_W]) + VISIT_W'(1);
                    n_iss_k  = '0;
                    n_iss_w  = s0[SLOT_W-1:BIT_W];
                    n_rsp    = '0;
                    if (i_req.operation == OP_ACQUIRE) begin
                        if (size_eff == '0) begin
                            n_done       = 1'b1;
                            n_rsp.status = ST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (SLOT_W'(i_req.release_index) >= size_eff) begin
                            n_done       = 1'b1;
                            n_rsp.status = ST_BAD;
                        end else begin
                            n_state = S_REL;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_iss_k <= r_nwords) begin
                    n_dv    = 1'b1;
                    n_dk    = r_iss_k;
                    n_dw    = r_iss_w;
                    n_iss_k = r_iss_k + VISIT_W'(1);
                    n_iss_w = (r_iss_w == r_last_w) ? '0 : r_iss_w + WSEL_W'(1);
                end
                if (hit) begin
                    n_state             = S_IDLE;
                    n_done              = 1'b1;
                    n_search            = slot;
                    n_rsp.granted_index = slot[IDX_W-1:0];
                    n_rsp.status        = ST_OK;
                end else if (r_dv && r_dk == r_nwords) begin
                    n_state             = S_IDLE;
                    n_done              = 1'b1;
                    n_rsp.granted_index = '0;
                    n_rsp.status        = ST_FULL;
                end
            end
            S_REL: begin
                n_state = S_RCHK;
            end
            S_RCHK: begin
                n_state      = S_IDLE;
                n_done       = 1'b1;
                n_rsp.status = ram_rdata[r_rel[BIT_W-1:0]] ? ST_OK : ST_BAD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_active <= SLOT_W'(1024);
            r_search <= '0;
            r_done   <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_active <= n_active;
            r_search <= n_search;
            r_done   <= n_done;
            r_dv     <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_s0     <= n_s0;
        r_rel    <= n_rel;
        r_last_w <= n_last_w;
        r_last_n <= n_last_n;
        r_nwords <= n_nwords;
        r_iss_k  <= n_iss_k;
        r_iss_w  <= n_iss_w;
        r_dk     <= n_dk;
        r_dw     <= n_dw;
        r_rsp    <= n_rsp;
    end

`ifndef SYNTH
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept) || $past(r_state == S_SCAN) || $past(r_state == S_RCHK))
        else $error("response word without a command");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_OK) |-> (SLOT_W'(o_rsp.granted_index) < r_size))
        else $error("granted slot outside active range");

    a_search_follows_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_OK && $past(r_state == S_SCAN))
            |-> (r_search[IDX_W-1:0] == o_rsp.granted_index))
        else $error("search position not moved to granted slot");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_iss_k <= r_nwords + VISIT_W'(1)))
        else $error("scan ran past the wrap visit");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit bitmap slot allocator. A queued driver
// sends acquire and release words with random gaps and rewrites the active
// size between phases once the block has gone idle. A monitor keeps its own
// bitmap, search position and size, predicts each response word when its
// command is taken, and compares the response words in order.
// ----------------------------------------------------------------------------
module tb_top;
    import nfba_pkg::*;

    localparam int MAX_SLOTS    = 1024;
    localparam int SETTLE       = 4;
    localparam int PHASE_ITEMS  = 45;
    localparam int LIMIT_TIME   = 4_000_000;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_PAUSE
    } t_entry_kind;

    typedef struct {
        t_entry_kind         kind;
        t_alloc_req          req;
        logic [SLOT_W-1:0]   size;
        int                  gap;
    } t_cmd_entry;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_alloc_req          req_word = '0;
    logic                o_done;
    t_alloc_rsp          rsp_word;
    logic                cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SLOT_W-1:0]   cfg_data = '0;

    t_cmd_entry          cmd_q[$];
    t_alloc_rsp          grant_q[$];

    logic [MAX_SLOTS-1:0] mark_map;
    logic [IDX_W-1:0]     scan_from;
    logic [SLOT_W-1:0]    slot_count;

    bit                  next_start;
    bit                  next_cfg;
    int                  gap_left;
    int                  quiet;
    int                  n_sent;
    int                  n_done;
    int                  n_bad;
    int                  n_granted;
    int                  n_full;
    int                  n_bad_release;
    int                  n_cfg;

    next_fit_bitmap_id_allocator #(
        .MAX_SLOTS (MAX_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req_word),
        .o_done      (o_done),
        .o_rsp       (rsp_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("timeout: %0d of %0d words answered", n_done, n_sent);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_item(logic op, logic [IDX_W-1:0] idx, int gap);
        t_cmd_entry e;
        e.kind = ENT_ITEM;
        e.req.operation = op;
        e.req.release_index = idx;
        e.size = '0;
        e.gap = gap;
        cmd_q.push_back(e);
    endfunction

    function automatic void push_ctrl(t_entry_kind kind, logic [SLOT_W-1:0] size);
        t_cmd_entry e;
        e.kind = kind;
        e.req = '0;
        e.size = size;
        e.gap = 0;
        cmd_q.push_back(e);
    endfunction

    function automatic t_alloc_rsp next_fit_grant(t_alloc_req r);
        t_alloc_rsp rsp;
        int unsigned span;
        int unsigned slot;
        int unsigned k;
        span = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
        rsp.granted_index = '0;
        if (r.operation == OP_ACQUIRE) begin
            rsp.status = ST_FULL;
            slot = (scan_from >= span) ? 0 : scan_from;
            for (k = 0; k < span; k++) begin
                if (!mark_map[slot]) begin
                    mark_map[slot] = 1'b1;
                    scan_from = slot[IDX_W-1:0];
                    rsp.granted_index = slot[IDX_W-1:0];
                    rsp.status = ST_OK;
                    break;
                end
                slot++;
                if (slot == span) slot = 0;
            end
        end else if (r.release_index >= span || !mark_map[r.release_index]) begin
            rsp.status = ST_BAD;
        end else begin
            mark_map[r.release_index] = 1'b0;
            rsp.status = ST_OK;
        end
        return rsp;
    endfunction

    // driver: hold each word until taken, then space the next by its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            quiet = 0;
            n_sent = 0;
        end else begin
            next_start = start;
            next_cfg = cfg_valid;
            if (start && !busy) begin
                n_sent++;
                next_start = 1'b0;
            end
            if (cfg_valid && o_cfg_ready) next_cfg = 1'b0;
            if (busy || start || cfg_valid || n_sent != n_done) quiet = 0;
            else quiet++;
            if (!next_start && !next_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0) begin
                    unique case (cmd_q[0].kind)
                        ENT_ITEM: begin
                            req_word <= cmd_q[0].req;
                            gap_left = cmd_q[0].gap;
                            next_start = 1'b1;
                            void'(cmd_q.pop_front());
                        end
                        ENT_CFG: begin
                            if (quiet >= SETTLE) begin
                                cfg_data <= cmd_q[0].size;
                                next_cfg = 1'b1;
                                void'(cmd_q.pop_front());
                            end
                        end
                        default: begin
                            if (quiet >= SETTLE) void'(cmd_q.pop_front());
                        end
                    endcase
                end
            end
            start <= next_start;
            cfg_valid <= next_cfg;
        end
    end

    // monitor: predict on command accept, check each response word in order
    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (!i_rst_n) begin
            mark_map = '0;
            scan_from = '0;
            slot_count = 11'd1024;
            grant_q.delete();
            n_done <= 0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                slot_count = cfg_data;
                n_cfg++;
            end
            if (start && !busy) begin
                want = next_fit_grant(req_word);
                grant_q.push_back(want);
                if (want.status == ST_FULL) n_full++;
                else if (want.status == ST_BAD) n_bad_release++;
                else if (req_word.operation == OP_ACQUIRE) n_granted++;
            end
            if (o_done) begin
                n_done <= n_done + 1;
                if (grant_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected response word: granted_index %0d status %0d",
                                 rsp_word.granted_index, rsp_word.status);
                end else begin
                    want = grant_q.pop_front();
                    if (rsp_word.granted_index !== want.granted_index ||
                        rsp_word.status !== want.status) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("word %0d: index exp %0d got %0d, status exp %0d got %0d",
                                     n_done, want.granted_index, rsp_word.granted_index,
                                     want.status, rsp_word.status);
                    end
                end
            end
        end
    end

    initial begin
        logic [SLOT_W-1:0] sizes[13];
        int unsigned eff;
        int unsigned acquired;
        int unsigned hi;
        int acq_pct;
        bit calm;
        logic op;
        logic [IDX_W-1:0] idx;
        int ph;
        int k;

        sizes = '{11'd1, 11'd2, 11'd7, 11'd63, 11'd64, 11'd65, 11'd0, 11'd130,
                  11'd1024, 11'd2047, 11'd1025, 11'd3, 11'd1};
        sizes[11] = SLOT_W'($urandom_range(3, 200));
        sizes[12] = SLOT_W'($urandom_range(1, 1024));

        push_item(OP_ACQUIRE, 10'h3FF, pick_gap());
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());
        push_item(OP_ACQUIRE, '0, pick_gap());
        push_item(OP_RELEASE, 10'd1, pick_gap());
        push_item(OP_RELEASE, 10'd1, pick_gap());
        push_item(OP_RELEASE, 10'h3FF, pick_gap());
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());
        push_item(OP_RELEASE, 10'd0, pick_gap());
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());
        // shrink below the search position, then fill up
        push_ctrl(ENT_CFG, 11'd4);
        push_item(OP_ACQUIRE, IDX_W'($urandom), 0);
        push_item(OP_ACQUIRE, IDX_W'($urandom), 0);
        push_item(OP_ACQUIRE, IDX_W'($urandom), 0);
        push_item(OP_RELEASE, 10'd5, 0);
        push_ctrl(ENT_CFG, 11'd0);
        push_item(OP_ACQUIRE, 10'h3FF, 0);
        push_item(OP_RELEASE, 10'd0, 0);
        push_ctrl(ENT_CFG, 11'd2047);
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());
        push_item(OP_RELEASE, 10'h3FF, pick_gap());
        push_ctrl(ENT_CFG, 11'd1);
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());
        push_item(OP_RELEASE, 10'd0, pick_gap());
        push_item(OP_ACQUIRE, IDX_W'($urandom), pick_gap());

        for (ph = 0; ph < 13; ph++) begin
            push_ctrl(ENT_CFG, sizes[ph]);
            eff = (sizes[ph] > MAX_SLOTS) ? MAX_SLOTS : sizes[ph];
            acq_pct = $urandom_range(30, 80);
            calm = ($urandom_range(0, 3) == 0);
            acquired = 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                idx = IDX_W'($urandom);
                if ($urandom_range(1, 100) <= acq_pct) begin
                    op = OP_ACQUIRE;
                    acquired++;
                end else begin
                    op = OP_RELEASE;
                    if (eff != 0 && $urandom_range(0, 3) != 0) begin
                        hi = (eff < acquired + 8) ? eff : acquired + 8;
                        idx = IDX_W'($urandom_range(0, hi - 1));
                    end
                end
                push_item(op, idx, calm ? 0 : pick_gap());
                if (k == PHASE_ITEMS / 2 && ph % 3 == 1) push_ctrl(ENT_PAUSE, '0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || cfg_valid || n_sent != n_done);
        repeat (30) @(negedge i_clk);

        if (grant_q.size() != 0) begin
            $display("%0d response words never arrived", grant_q.size());
            n_bad += grant_q.size();
        end
        $display("covered %0d command words over %0d active size settings", n_sent, n_cfg);
        $display("grants %0d, full acquires %0d, bad releases %0d, mismatches %0d",
                 n_granted, n_full, n_bad_release, n_bad);
        if (n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
